>>> rtl/gain_saturating_audio_mixer_top_macros.svh
// assertion macros for the mixer
`ifndef GAIN_SATURATING_AUDIO_MIXER_TOP_MACROS_SVH
`define GAIN_SATURATING_AUDIO_MIXER_TOP_MACROS_SVH

// same-cycle implication, reset masked
`define GSAM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mixer check failed");

// next-cycle implication, reset masked
`define GSAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mixer check failed");

`endif

>>> rtl/gsam_pkg.sv
package gsam_pkg;

  localparam int NUM_STREAMS         = 3;
  localparam int SAMPLE_W            = 16;
  localparam int GAIN_W              = 5;
  localparam int PROD_W              = SAMPLE_W + GAIN_W;
  localparam int MAG_W               = PROD_W - 1;
  localparam int CLIP_LIMIT          = 32760;
  localparam int GAIN_RESET          = 30;
  localparam int GAIN_FULL_SCALE_DEF = 30;
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 8;
  // product, quotient, gained sample, sum
  localparam int CELL_LAT            = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_A   = 3'd0,
    REG_GAIN_B   = 3'd1,
    REG_GAIN_C   = 3'd2,
    REG_ENABLE_A = 3'd3,
    REG_ENABLE_B = 3'd4,
    REG_ENABLE_C = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [NUM_STREAMS-1:0][GAIN_W-1:0] gain;
    logic [NUM_STREAMS-1:0]             enable;
  } cfg_t;

endpackage

>>> rtl/gsam_ifs.sv
interface gsam_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [gsam_pkg::SAMPLE_W-1:0]    sample_a;
  logic signed [gsam_pkg::SAMPLE_W-1:0]    sample_b;
  logic signed [gsam_pkg::SAMPLE_W-1:0]    sample_c;
  logic                                    fresh_a;
  logic                                    fresh_b;
  logic                                    fresh_c;

  modport source (output valid, sample_a, sample_b, sample_c, fresh_a, fresh_b, fresh_c,
                  input ready);
  modport sink (input valid, sample_a, sample_b, sample_c, fresh_a, fresh_b, fresh_c,
                output ready);
endinterface

interface gsam_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [gsam_pkg::SAMPLE_W-1:0]    mixed_sample;

  modport source (output valid, mixed_sample, input ready);
  modport sink (input valid, mixed_sample, output ready);
endinterface

interface gsam_cfg_if;
  logic                                    valid;
  logic                                    ready;
  logic [gsam_pkg::CFG_IDX_W-1:0]          index;
  logic [gsam_pkg::CFG_DATA_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/gain_saturating_audio_mixer_top.sv
// Three-stream saturating PCM mixer. Each input beat carries one sample per stream and a
// fresh flag; a stream that is enabled and fresh is scaled by gain/GAIN_FULL_SCALE
// (truncated toward zero, clipped to +/-32760) and added to a running sum that is clipped
// after each addition. One cell per stream holds the gain path and hands the partial sum
// to the next cell. One beat is taken every cycle unless the output stalls; a result passes
// through 4 stages in the first cell plus one sum stage per further cell, and the
// whole pipeline holds while the output beat is not taken. Configuration writes are
// always ready and take effect on the next cycle; they belong to idle periods.
`include "gain_saturating_audio_mixer_top_macros.svh"

module gain_saturating_audio_mixer_top #(
  parameter int unsigned GAIN_FULL_SCALE = gsam_pkg::GAIN_FULL_SCALE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  gsam_in_if.sink      in_ch,
  gsam_out_if.source   out_ch,
  gsam_cfg_if.sink     cfg_ch
);

  localparam int NS  = gsam_pkg::NUM_STREAMS;
  localparam int SW  = gsam_pkg::SAMPLE_W;
  localparam int LAT = gsam_pkg::CELL_LAT + NS - 1;

  gsam_pkg::cfg_t       cfg_r;
  logic                 adv;
  logic [LAT-1:0]       vld_r, vld_nxt;
  logic signed [SW-1:0] samples [NS];
  logic [NS-1:0]        fresh;
  logic signed [SW-1:0] sum_w [NS+1];
  logic                 out_in_range;

  gsam_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_r  (cfg_r)
  );

  assign adv          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign vld_nxt      = {vld_r[LAT-2:0], in_ch.valid};

  assign samples[0] = in_ch.sample_a;
  assign samples[1] = in_ch.sample_b;
  assign samples[2] = in_ch.sample_c;
  assign fresh      = {in_ch.fresh_c, in_ch.fresh_b, in_ch.fresh_a};
  assign sum_w[0]   = '0;

  generate
    for (genvar i = 0; i < NS; i++) begin : g_cell
      gsam_cell #(
        .FULL_SCALE (GAIN_FULL_SCALE),
        .SKEW       (i)
      ) u_cell (
        .clk       (clk),
        .adv       (adv),
        .act       (cfg_r.enable[i] && fresh[i]),
        .sample    (samples[i]),
        .gain      (cfg_r.gain[i]),
        .sum_in    (sum_w[i]),
        .sum_out_r (sum_w[i+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  assign out_ch.valid        = vld_r[LAT-1];
  assign out_ch.mixed_sample = sum_w[NS];

  assign out_in_range = (out_ch.mixed_sample <= 16'sd32760)
                     && (out_ch.mixed_sample >= -16'sd32760);

  `GSAM_ASSERT_NOW(a_out_range, out_ch.valid, out_in_range)
  `GSAM_ASSERT_NEXT(a_fill, vld_r[LAT-2] && adv, out_ch.valid)
  `GSAM_ASSERT_NEXT(a_drain, !vld_r[LAT-2] && adv, !out_ch.valid)

endmodule

>>> rtl/gsam_cfg.sv
module gsam_cfg (
  input  logic            clk,
  input  logic            rst_n,
  gsam_cfg_if.sink        cfg_ch,
  output gsam_pkg::cfg_t  cfg_r
);

  gsam_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (gsam_pkg::cfg_reg_t'(cfg_ch.index))
        gsam_pkg::REG_GAIN_A:   cfg_nxt.gain[0]   = cfg_ch.data[gsam_pkg::GAIN_W-1:0];
        gsam_pkg::REG_GAIN_B:   cfg_nxt.gain[1]   = cfg_ch.data[gsam_pkg::GAIN_W-1:0];
        gsam_pkg::REG_GAIN_C:   cfg_nxt.gain[2]   = cfg_ch.data[gsam_pkg::GAIN_W-1:0];
        gsam_pkg::REG_ENABLE_A: cfg_nxt.enable[0] = cfg_ch.data[0];
        gsam_pkg::REG_ENABLE_B: cfg_nxt.enable[1] = cfg_ch.data[0];
        gsam_pkg::REG_ENABLE_C: cfg_nxt.enable[2] = cfg_ch.data[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gsam_pkg::NUM_STREAMS; i++) begin
        cfg_r.gain[i]   <= gsam_pkg::GAIN_W'(gsam_pkg::GAIN_RESET);
        cfg_r.enable[i] <= 1'b0;
      end
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/gsam_cell.sv
module gsam_cell #(
  parameter int unsigned FULL_SCALE = gsam_pkg::GAIN_FULL_SCALE_DEF,
  parameter int unsigned SKEW       = 0
) (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic                                 act,
  input  logic signed [gsam_pkg::SAMPLE_W-1:0] sample,
  input  logic [gsam_pkg::GAIN_W-1:0]          gain,
  input  logic signed [gsam_pkg::SAMPLE_W-1:0] sum_in,
  output logic signed [gsam_pkg::SAMPLE_W-1:0] sum_out_r
);

  localparam int SW      = gsam_pkg::SAMPLE_W;
  localparam int PW      = gsam_pkg::PROD_W;
  localparam int MW      = gsam_pkg::MAG_W;
  localparam int RECIP_K = MW + 8;
  localparam int WIDE_W  = MW + RECIP_K + 1;
  localparam logic [RECIP_K:0] RECIP_M =
    (RECIP_K + 1)'(((64'd1 << RECIP_K) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));

  logic signed [PW-1:0]  prod_r, prod_nxt;
  logic                  neg_r;
  logic [MW-1:0]         mag;
  logic [WIDE_W-1:0]     wide;
  logic [MW-1:0]         quo_r, quo_nxt;
  logic [SW-1:0]         mag_clip;
  logic signed [SW-1:0]  gained_r, gained_nxt;
  logic signed [SW-1:0]  aligned;
  logic signed [SW:0]    sum_wide;
  logic signed [SW:0]    lim;
  logic signed [SW-1:0]  sum_nxt;

  // stage 1: sample times gain
  always_comb begin
    if (act) begin
      prod_nxt = $signed({{(PW - SW){sample[SW-1]}}, sample})
               * $signed({{(PW - gsam_pkg::GAIN_W){1'b0}}, gain});
    end else begin
      prod_nxt = '0;
    end
  end

  // stage 2: magnitude over full scale by reciprocal multiply
  always_comb begin
    mag     = prod_r[PW-1] ? MW'(-prod_r) : MW'(prod_r);
    wide    = WIDE_W'(mag) * WIDE_W'(RECIP_M);
    quo_nxt = wide[RECIP_K +: MW];
  end

  // stage 3: clip and restore sign
  always_comb begin
    mag_clip   = (quo_r >= MW'(gsam_pkg::CLIP_LIMIT)) ? SW'(gsam_pkg::CLIP_LIMIT)
                                                      : quo_r[SW-1:0];
    gained_nxt = neg_r ? -$signed(mag_clip) : $signed(mag_clip);
  end

  generate
    if (SKEW == 0) begin : g_noskew
      assign aligned = gained_r;
    end else begin : g_skew
      logic signed [SW-1:0] skew_r [SKEW];
      always_ff @(posedge clk) begin
        if (adv) begin
          skew_r[0] <= gained_r;
          for (int k = 1; k < SKEW; k++) begin
            skew_r[k] <= skew_r[k-1];
          end
        end
      end
      assign aligned = skew_r[SKEW-1];
    end
  endgenerate

  // running sum from the previous cell, clipped
  always_comb begin
    lim      = (SW + 1)'(gsam_pkg::CLIP_LIMIT);
    sum_wide = {sum_in[SW-1], sum_in} + {aligned[SW-1], aligned};
    priority if (sum_wide >= lim) begin
      sum_nxt = SW'(lim);
    end else if (sum_wide <= -lim) begin
      sum_nxt = SW'(-lim);
    end else begin
      sum_nxt = sum_wide[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r    <= prod_nxt;
      neg_r     <= prod_r[PW-1];
      quo_r     <= quo_nxt;
      gained_r  <= gained_nxt;
      sum_out_r <= sum_nxt;
    end
  end

endmodule
